FILE: rtl/core/subarray_xor_match_counter_assert.svh
// ----------------------------------------------------------------------------
// Subarray XOR match counter - assertion macros
// Shorthand for the concurrent checks in the checker file.
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_XOR_MATCH_COUNTER_ASSERT_SVH
`define SUBARRAY_XOR_MATCH_COUNTER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define SXMC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define SXMC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sxmc_pkg.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - shared package
// Fixed field widths, table epoch width, output queue sizing and shared types.
// ----------------------------------------------------------------------------
package sxmc_pkg;

    // Port field widths
    localparam int ELEMENT_W = 10;
    localparam int TARGET_W  = 10;
    localparam int RESULT_W  = 32;

    // Table entries carry an epoch tag so a new array needs no clear
    localparam int EPOCH_BITS = 8;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [RESULT_W-1:0] total;
        logic [RESULT_W-1:0] here;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_start;
    } tbl_ctl_t;

endpackage

FILE: rtl/core/sxmc_if.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - channel interfaces
// Valid/ready channels for items, results and the target register write.
// ----------------------------------------------------------------------------
interface sxmc_item_if;
    logic                           valid;
    logic                           ready;
    logic [sxmc_pkg::ELEMENT_W-1:0] element;
    logic                           start_of_array;

    modport source (output valid, output element, output start_of_array, input ready);
    modport sink   (input valid, input element, input start_of_array, output ready);
endinterface

interface sxmc_result_if;
    logic                          valid;
    logic                          ready;
    logic [sxmc_pkg::RESULT_W-1:0] total_matches;
    logic [sxmc_pkg::RESULT_W-1:0] matches_ending_here;

    modport source (output valid, output total_matches, output matches_ending_here,
                    input ready);
    modport sink   (input valid, input total_matches, input matches_ending_here,
                    output ready);
endinterface

interface sxmc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sxmc_pkg::TARGET_W-1:0] match_target;

    modport source (output valid, output match_target, input ready);
    modport sink   (input valid, input match_target, output ready);
endinterface

FILE: rtl/core/subarray_xor_match_counter.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - top level
// Counts contiguous subarrays whose XOR equals the match target, one element
// per transaction on the items channel. A transaction with start_of_array set
// opens a new array: prefix, total and prefix count table start from zero.
// Each item yields exactly one transaction on the results channel carrying
// the saturating running total and the matches ending at that element.
// The target register is written through the cfg channel, always ready.
// An accepted item passes the table read, the running total and the result
// queue in that order before its result is valid; one item per cycle is
// sustained while results are taken and no table sweep runs, set by the
// single read-modify-write of the table memory per item (write forwarded to
// the next read of the same entry). After reset the table memory is swept
// with items.ready low. Table entries carry an 8-bit array tag; when the tag
// is at its last value, the next start item waits for another sweep of the
// table. When results stalls, a four-entry result queue absorbs work in
// flight and items.ready drops once it would overflow.
// ----------------------------------------------------------------------------
module subarray_xor_match_counter #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    sxmc_item_if.sink     items,
    sxmc_result_if.source results,
    sxmc_cfg_if.sink      cfg
);

    localparam int EB    = sxmc_pkg::EPOCH_BITS;
    localparam int RW    = sxmc_pkg::RESULT_W;
    localparam int CW    = sxmc_pkg::OUT_CNT_W;
    localparam int SUM_W = COUNT_BITS + 1;

    // Configuration
    logic [sxmc_pkg::TARGET_W-1:0] target_reg;

    // Array state kept at the input side
    logic [VALUE_BITS-1:0] prefix_reg;
    logic [EB-1:0]         epoch_reg;

    // Stage 0: acceptance
    logic                  accept;
    logic                  space;
    logic [CW:0]           in_flight;
    logic                  epoch_wrap;
    logic [VALUE_BITS-1:0] tgt;
    logic [VALUE_BITS-1:0] prefix_next;
    logic [VALUE_BITS-1:0] wanted;
    logic [EB-1:0]         epoch_next;

    // Stage 1: table data back
    logic                  s1_valid_reg;
    logic [VALUE_BITS-1:0] s1_prefix_reg;
    logic                  s1_match_reg;
    logic                  s1_start_reg;
    logic [EB-1:0]         s1_epoch_reg;
    logic [COUNT_BITS-1:0] cnt_wanted;
    logic [COUNT_BITS-1:0] cnt_prefix;
    logic [SUM_W-1:0]      here_sum;
    logic [SUM_W-1:0]      inc_sum;
    logic [COUNT_BITS-1:0] here;
    logic [COUNT_BITS-1:0] prefix_inc;

    // Stage 2: running total
    logic                  s2_valid_reg;
    logic [COUNT_BITS-1:0] s2_here_reg;
    logic                  s2_start_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_base;
    logic [SUM_W-1:0]      total_sum;
    logic [COUNT_BITS-1:0] total_next;

    sxmc_pkg::tbl_ctl_t    tbl_ctl;
    logic                  clr_busy;
    logic [CW-1:0]         fill;
    sxmc_pkg::result_t     push_data;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg.valid)
        begin
            target_reg <= cfg.match_target;
        end
    end

    // ---------------------------------------------------------------- stage 0
    // Reserve a queue slot for every item in flight so nothing is dropped
    // when the receiver stalls.
    always_comb
    begin
        in_flight = {1'b0, fill} + (CW + 1)'(s1_valid_reg) + (CW + 1)'(s2_valid_reg);
        space     = (in_flight < (CW + 1)'(sxmc_pkg::OUT_DEPTH));
    end

    // A new array at the last tag value must wait for a sweep of the table.
    assign epoch_wrap  = (epoch_reg == '1) & items.start_of_array;
    assign items.ready = space & ~clr_busy & ~epoch_wrap;
    assign accept      = items.valid & items.ready;

    always_comb
    begin
        tgt         = VALUE_BITS'(target_reg);
        prefix_next = (items.start_of_array ? '0 : prefix_reg)
                    ^ VALUE_BITS'(items.element);
        wanted      = prefix_next ^ tgt;
        epoch_next  = items.start_of_array ? epoch_reg + 1'b1 : epoch_reg;
    end

    // Start the sweep only once the last write of the old array has landed.
    always_comb
    begin
        tbl_ctl.rd_en     = accept;
        tbl_ctl.wr_en     = s1_valid_reg;
        tbl_ctl.clr_start = items.valid & epoch_wrap & ~clr_busy & ~s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            epoch_reg  <= '0;
        end
        else if (tbl_ctl.clr_start)
        begin
            epoch_reg <= '0;
        end
        else if (accept)
        begin
            prefix_reg <= prefix_next;
            epoch_reg  <= epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prefix_reg <= prefix_next;
            s1_match_reg  <= (prefix_next == tgt);
            s1_start_reg  <= items.start_of_array;
            s1_epoch_reg  <= epoch_next;
        end
    end

    // ---------------------------------------------------------------- table
    sxmc_table #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tbl_ctl),
        .rd_addr_a (wanted),
        .rd_addr_b (prefix_next),
        .rd_epoch  (s1_epoch_reg),
        .wr_addr   (s1_prefix_reg),
        .wr_epoch  (s1_epoch_reg),
        .wr_count  (prefix_inc),
        .cnt_a     (cnt_wanted),
        .cnt_b     (cnt_prefix),
        .clr_busy  (clr_busy)
    );

    // ---------------------------------------------------------------- stage 1
    // Matches here: earlier prefixes equal to prefix ^ target, plus the whole
    // array so far when the prefix itself hits the target. Saturate on carry.
    always_comb
    begin
        here_sum   = {1'b0, cnt_wanted} + SUM_W'(s1_match_reg);
        inc_sum    = {1'b0, cnt_prefix} + SUM_W'(1);
        here       = here_sum[COUNT_BITS] ? '1 : here_sum[COUNT_BITS-1:0];
        prefix_inc = inc_sum[COUNT_BITS]  ? '1 : inc_sum[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_here_reg  <= here;
            s2_start_reg <= s1_start_reg;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        total_base = s2_start_reg ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + {1'b0, s2_here_reg};
        total_next = total_sum[COUNT_BITS] ? '1 : total_sum[COUNT_BITS-1:0];
        push_data.total = RW'(total_next);
        push_data.here  = RW'(s2_here_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                total_reg <= total_next;
            end
        end
    end

    // ---------------------------------------------------------------- results
    sxmc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .fill      (fill),
        .results   (results)
    );

endmodule

FILE: rtl/core/sxmc_table.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - prefix count table
// Epoch-tagged count memory, two registered reads and one write per cycle,
// with forwarding of the write made on the read edge and a clearing sweep.
// ----------------------------------------------------------------------------
module sxmc_table #(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sxmc_pkg::tbl_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0]           rd_addr_a,
    input  logic [VALUE_BITS-1:0]           rd_addr_b,
    input  logic [sxmc_pkg::EPOCH_BITS-1:0] rd_epoch,
    input  logic [VALUE_BITS-1:0]           wr_addr,
    input  logic [sxmc_pkg::EPOCH_BITS-1:0] wr_epoch,
    input  logic [COUNT_BITS-1:0]           wr_count,
    output logic [COUNT_BITS-1:0]           cnt_a,
    output logic [COUNT_BITS-1:0]           cnt_b,
    output logic                            clr_busy
);

    localparam int EB      = sxmc_pkg::EPOCH_BITS;
    localparam int DEPTH   = 1 << VALUE_BITS;
    localparam int ENTRY_W = EB + COUNT_BITS;

    logic [ENTRY_W-1:0]    mem [DEPTH];

    logic [ENTRY_W-1:0]    rd_a_reg;
    logic [ENTRY_W-1:0]    rd_b_reg;
    logic [VALUE_BITS-1:0] rd_addr_a_reg;
    logic [VALUE_BITS-1:0] rd_addr_b_reg;

    logic                  fwd_valid_reg;
    logic [VALUE_BITS-1:0] fwd_addr_reg;
    logic [ENTRY_W-1:0]    fwd_entry_reg;

    logic                  clr_busy_reg;
    logic                  clr_busy_next;
    logic [VALUE_BITS-1:0] clr_ptr_reg;
    logic [VALUE_BITS-1:0] clr_ptr_next;

    logic                  mem_we;
    logic [VALUE_BITS-1:0] mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ENTRY_W-1:0]    sel_a;
    logic [ENTRY_W-1:0]    sel_b;

    assign clr_busy = clr_busy_reg;

    always_comb
    begin
        mem_we    = clr_busy_reg | ctl.wr_en;
        mem_waddr = clr_busy_reg ? clr_ptr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? '0 : {wr_epoch, wr_count};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_a_reg      <= mem[rd_addr_a];
            rd_b_reg      <= mem[rd_addr_b];
            rd_addr_a_reg <= rd_addr_a;
            rd_addr_b_reg <= rd_addr_b;
        end
        fwd_addr_reg  <= wr_addr;
        fwd_entry_reg <= {wr_epoch, wr_count};
    end

    // A write on the read edge is not seen by the read: take it from here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ctl.wr_en;
        end
    end

    always_comb
    begin
        sel_a = (fwd_valid_reg && (fwd_addr_reg == rd_addr_a_reg)) ? fwd_entry_reg : rd_a_reg;
        sel_b = (fwd_valid_reg && (fwd_addr_reg == rd_addr_b_reg)) ? fwd_entry_reg : rd_b_reg;
        // An entry from an older array reads as zero
        cnt_a = (sel_a[ENTRY_W-1 -: EB] == rd_epoch) ? sel_a[COUNT_BITS-1:0] : '0;
        cnt_b = (sel_b[ENTRY_W-1 -: EB] == rd_epoch) ? sel_b[COUNT_BITS-1:0] : '0;
    end

    always_comb
    begin
        priority if (ctl.clr_start)
        begin
            clr_busy_next = 1'b1;
            clr_ptr_next  = '0;
        end
        else if (clr_busy_reg)
        begin
            clr_busy_next = (clr_ptr_reg != '1);
            clr_ptr_next  = clr_ptr_reg + 1'b1;
        end
        else
        begin
            clr_busy_next = 1'b0;
            clr_ptr_next  = clr_ptr_reg;
        end
    end

    // Sweep the whole memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_ptr_reg  <= clr_ptr_next;
        end
    end

endmodule

FILE: rtl/core/sxmc_out_fifo.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - result queue
// Small queue between the count pipeline and the result channel.
// ----------------------------------------------------------------------------
module sxmc_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  sxmc_pkg::result_t              push_data,
    output logic [sxmc_pkg::OUT_CNT_W-1:0] fill,
    sxmc_result_if.source                  results
);

    localparam int PW = sxmc_pkg::OUT_PTR_W;
    localparam int CW = sxmc_pkg::OUT_CNT_W;

    sxmc_pkg::result_t slot_reg [sxmc_pkg::OUT_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          pop;

    assign pop                         = results.valid & results.ready;
    assign fill                        = fill_reg;
    assign results.valid               = (fill_reg != '0);
    assign results.total_matches       = slot_reg[rd_ptr_reg].total;
    assign results.matches_ending_here = slot_reg[rd_ptr_reg].here;

    always_comb
    begin
        fill_next = fill_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: rtl/core/sxmc_checker.sv
// ----------------------------------------------------------------------------
// Subarray XOR match counter - port checker
// Watches the top-level channels: one result per item, bounded work in flight.
// ----------------------------------------------------------------------------
`include "subarray_xor_match_counter_assert.svh"

module sxmc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [sxmc_pkg::RESULT_W-1:0] total_matches,
    input logic [sxmc_pkg::RESULT_W-1:0] matches_ending_here
);

    logic [3:0] pending_reg;
    logic       item_take;
    logic       result_take;

    assign item_take   = item_valid & item_ready;
    assign result_take = result_valid & result_ready;

    // Items accepted whose result has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(item_take) - 4'(result_take);
        end
    end

    `SXMC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(total_matches) && $stable(matches_ending_here), "stalled result changed")

    `SXMC_ASSERT_NOW(a_result_has_item, clk, rst_n, result_valid, pending_reg != 4'd0, "result without an accepted item")

    `SXMC_ASSERT_NOW(a_pending_bound, clk, rst_n, 1'b1, pending_reg <= 4'(sxmc_pkg::OUT_DEPTH), "more items in flight than result slots")

endmodule

bind subarray_xor_match_counter sxmc_checker u_sxmc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (items.valid),
    .item_ready          (items.ready),
    .result_valid        (results.valid),
    .result_ready        (results.ready),
    .total_matches       (results.total_matches),
    .matches_ending_here (results.matches_ending_here)
);
